[hw/rtl/tfpg_pkg.sv]
// ---------------------------------------------------------------------------
// tfpg_pkg - shared types and constants for the fire permission gate
// Field widths, fixed-point angle constants, CORDIC arctangent table,
// configuration register indexes and the per-item control word.
// ---------------------------------------------------------------------------
package tfpg_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_TOL   = 3'd0,
        CFG_FAR_TOL    = 3'd1,
        CFG_JUDGE_DIST = 3'd2,
        CFG_AUTO_FIRE  = 3'd3,
        CFG_SPIN_ANGLE = 3'd4
    } t_cfg_idx;

    // field widths
    localparam int TOL_W  = 13;
    localparam int DIST_W = 16;
    localparam int SPIN_W = 14;
    localparam int POS_W  = 18;
    localparam int YAW_W  = 16;
    localparam int CNT_W  = 3;
    localparam int ARMOR_PORTS = 4;

    // squared range: x^2 and y^2 fit 35 bits each, their sum 36
    localparam int SQ_W    = 2 * POS_W - 1;
    localparam int RANGE_W = SQ_W + 1;
    localparam int JSQ_W   = 2 * DIST_W;

    // reset values
    localparam logic [TOL_W-1:0]  NEAR_TOL_RST   = 13'd71;
    localparam logic [TOL_W-1:0]  FAR_TOL_RST    = 13'd36;
    localparam logic [DIST_W-1:0] JUDGE_DIST_RST = 16'd3000;
    localparam logic              AUTO_FIRE_RST  = 1'b0;
    localparam logic [SPIN_W-1:0] SPIN_ANGLE_RST = 14'd1072;

    typedef struct packed {
        logic [TOL_W-1:0]  near_tol;
        logic [TOL_W-1:0]  far_tol;
        logic [DIST_W-1:0] judge_dist;
        logic              auto_fire;
        logic [SPIN_W-1:0] spin_angle;
    } t_cfg;

    // CORDIC vectoring: positions scaled by 2^12, angle in Q.16
    localparam int SCALE_SH         = 12;
    localparam int CORDIC_W         = 34;
    localparam int Z_W              = 21;
    localparam int ROUND_SH         = 4;
    localparam int BEAR_W           = Z_W - ROUND_SH;
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_PER_STAGE = 4;
    localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam int ATAN_W           = 16;
    localparam int ATAN_IDX_W       = $clog2(CORDIC_STEPS);

    localparam logic [ATAN_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2
    };

    localparam logic signed [Z_W-1:0] PI_Q16    = 21'sd205887;
    localparam logic signed [Z_W-1:0] ROUND_ADD = 21'sd8;

    // armor offset wrap, Q3.12
    localparam int WRAP_W = 19;
    localparam logic signed [WRAP_W-1:0] PI_Q12     = 19'sd12868;
    localparam logic signed [WRAP_W-1:0] TWO_PI_Q12 = 19'sd25736;

    typedef struct packed {
        logic [CORDIC_W-1:0] x;
        logic [CORDIC_W-1:0] y;
        logic [Z_W-1:0]      z;
    } t_cordic;

    // control word carried down the pipe
    typedef struct packed {
        logic             gate;    // engaged and auto fire on
        logic             aim;
        logic             center;
        logic [CNT_W-1:0] count;
        logic             origin;  // target at x = y = 0
        logic             pass;    // yaw tolerance and aim checks met
    } t_ctl;

endpackage

[hw/rtl/turret_fire_permission_gate.sv]
// ---------------------------------------------------------------------------
// turret_fire_permission_gate - per-tick turret fire permission
// Pipelined decision: yaw tolerance checks, squared range compare, CORDIC
// center bearing and per-armor facing checks; one tick per cycle unless stalled.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one control tick per transfer.
//   Output channel (o_valid / i_stall) returns one o_fire bit per tick, in
//   order. Configuration is a plain write port (i_cfg_we, i_cfg_idx,
//   i_cfg_data), to be written only while no tick is in flight; the block
//   itself does not enforce this. Pipe: input register, product stage,
//   four CORDIC stages of four iterations, bearing register, output
//   register. One tick per cycle unless the receiver stalls; the 16-step
//   CORDIC is spread over four stages so a new tick can enter every cycle.
//   The stored command yaw is updated at the input transfer of every engaged
//   tick with auto fire on, so back-to-back ticks see it without a bubble.
//   Reset: registers take their defaults, stored yaw is zero, pipe empty.
//   Receiver stall: the output holds; empty stages keep filling, and o_stall
//   rises only once all seven stages and the output register are occupied.
// ---------------------------------------------------------------------------
module turret_fire_permission_gate
    import tfpg_pkg::*;
#(
    parameter int MAX_ARMORS = 4
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_engaged,
    input  logic signed [POS_W-1:0]  i_target_x,
    input  logic signed [POS_W-1:0]  i_target_y,
    input  logic signed [YAW_W-1:0]  i_command_yaw,
    input  logic signed [YAW_W-1:0]  i_gimbal_yaw,
    input  logic                     i_aim_point_valid,
    input  logic                     i_center_track_active,
    input  logic [CNT_W-1:0]         i_armor_count,
    input  logic signed [YAW_W-1:0]  i_armor_yaw_0,
    input  logic signed [YAW_W-1:0]  i_armor_yaw_1,
    input  logic signed [YAW_W-1:0]  i_armor_yaw_2,
    input  logic signed [YAW_W-1:0]  i_armor_yaw_3,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_fire
);

    // stage numbering: 0 input, 1 products, 2..5 CORDIC, 6 bearing
    localparam int NST = CORDIC_STAGES + 3;

    t_cfg w_cfg;

    tfpg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // ---------------- pipe control ----------------
    logic [NST-1:0] r_vld, n_vld, w_move;
    logic           r_o_valid, n_o_valid, r_o_fire, n_o_fire;
    logic           w_out_rdy, w_in_acc;

    assign w_out_rdy = !r_o_valid || !i_stall;

    // a stage moves when it holds a tick and the next one is empty or moving
    always_comb begin
        w_move[NST-1] = r_vld[NST-1] && w_out_rdy;
        for (int k = NST - 2; k >= 0; k--) begin
            w_move[k] = r_vld[k] && (!r_vld[k+1] || w_move[k+1]);
        end
    end

    assign o_stall  = r_vld[0] && !w_move[0];
    assign w_in_acc = i_valid && !o_stall;

    always_comb begin
        n_vld[0] = w_in_acc ? 1'b1 : (w_move[0] ? 1'b0 : r_vld[0]);
        for (int k = 1; k < NST; k++) begin
            n_vld[k] = w_move[k-1] ? 1'b1 : (w_move[k] ? 1'b0 : r_vld[k]);
        end
        n_o_valid = w_move[NST-1] ? 1'b1 : ((r_o_valid && !i_stall) ? 1'b0 : r_o_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_vld     <= n_vld;
            r_o_valid <= n_o_valid;
        end
    end

    // ---------------- stored command yaw ----------------
    logic signed [YAW_W-1:0] r_prev;
    logic                    w_gate;

    assign w_gate = i_engaged && w_cfg.auto_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (w_in_acc && w_gate) begin
            r_prev <= i_command_yaw;
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [ARMOR_PORTS-1:0][YAW_W-1:0] w_arm_all;
    logic [MAX_ARMORS-1:0][YAW_W-1:0]  r0_arm;
    logic signed [POS_W-1:0]           r0_tx, r0_ty;
    logic signed [YAW_W-1:0]           r0_cmd, r0_gim, r0_prev;
    t_ctl                              r0_ctl;

    assign w_arm_all = {i_armor_yaw_3, i_armor_yaw_2, i_armor_yaw_1, i_armor_yaw_0};

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r0_tx         <= i_target_x;
            r0_ty         <= i_target_y;
            r0_cmd        <= i_command_yaw;
            r0_gim        <= i_gimbal_yaw;
            r0_prev       <= r_prev;
            r0_ctl.gate   <= w_gate;
            r0_ctl.aim    <= i_aim_point_valid;
            r0_ctl.center <= i_center_track_active;
            r0_ctl.count  <= i_armor_count;
            r0_ctl.origin <= (i_target_x == '0) && (i_target_y == '0);
            r0_ctl.pass   <= 1'b0;
            for (int k = 0; k < MAX_ARMORS; k++) begin
                r0_arm[k] <= w_arm_all[k];
            end
        end
    end

    // ---------------- stage 1: squares, yaw errors, CORDIC setup ----------------
    logic signed [2*POS_W-1:0]   w_sqx, w_sqy;
    logic [JSQ_W-1:0]            w_jsq;
    logic signed [YAW_W:0]       w_dcmd, w_dgim;
    logic [YAW_W-1:0]            w_acmd, w_agim;
    logic signed [CORDIC_W-1:0]  w_x0, w_y0;
    logic signed [Z_W-1:0]       w_z0;

    logic [SQ_W-1:0]                  r1_sqx, r1_sqy;
    logic [JSQ_W-1:0]                 r1_jsq;
    logic [YAW_W-1:0]                 r1_acmd, r1_agim;
    t_cordic                          r1_cor;
    t_ctl                             r1_ctl;
    logic [MAX_ARMORS-1:0][YAW_W-1:0] r1_arm;

    always_comb begin
        w_sqx  = r0_tx * r0_tx;
        w_sqy  = r0_ty * r0_ty;
        w_jsq  = w_cfg.judge_dist * w_cfg.judge_dist;
        w_dcmd = (YAW_W+1)'(r0_prev) - (YAW_W+1)'(r0_cmd);
        w_dgim = (YAW_W+1)'(r0_gim) - (YAW_W+1)'(r0_prev);
        w_acmd = w_dcmd[YAW_W] ? YAW_W'(-w_dcmd) : w_dcmd[YAW_W-1:0];
        w_agim = w_dgim[YAW_W] ? YAW_W'(-w_dgim) : w_dgim[YAW_W-1:0];
        // left half plane: reflect and start from +-pi
        w_x0 = CORDIC_W'(r0_tx) <<< SCALE_SH;
        w_y0 = CORDIC_W'(r0_ty) <<< SCALE_SH;
        w_z0 = '0;
        if (r0_tx[POS_W-1]) begin
            w_z0 = r0_ty[POS_W-1] ? -PI_Q16 : PI_Q16;
            w_x0 = -w_x0;
            w_y0 = -w_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move[0]) begin
            r1_sqx   <= w_sqx[SQ_W-1:0];
            r1_sqy   <= w_sqy[SQ_W-1:0];
            r1_jsq   <= w_jsq;
            r1_acmd  <= w_acmd;
            r1_agim  <= w_agim;
            r1_cor.x <= w_x0;
            r1_cor.y <= w_y0;
            r1_cor.z <= w_z0;
            r1_ctl   <= r0_ctl;
            r1_arm   <= r0_arm;
        end
    end

    // ---------------- stage 2 entry: tolerance decision ----------------
    logic [RANGE_W-1:0] w_range2;
    logic [TOL_W-1:0]   w_tol;
    t_ctl               w_ctl_s2;

    always_comb begin
        w_range2      = RANGE_W'(r1_sqx) + RANGE_W'(r1_sqy);
        w_tol         = (w_range2 > RANGE_W'(r1_jsq)) ? w_cfg.far_tol : w_cfg.near_tol;
        w_ctl_s2      = r1_ctl;
        w_ctl_s2.pass = (r1_acmd < YAW_W'({w_tol, 1'b0}))
                     && (r1_agim < YAW_W'(w_tol))
                     && r1_ctl.aim;
    end

    // ---------------- stages 2..5: CORDIC ----------------
    t_cordic                          r_c_cor [CORDIC_STAGES];
    t_ctl                             r_c_ctl [CORDIC_STAGES];
    logic [MAX_ARMORS-1:0][YAW_W-1:0] r_c_arm [CORDIC_STAGES];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cor
        t_cordic                          w_in, w_out;
        t_ctl                             w_ctl_in;
        logic [MAX_ARMORS-1:0][YAW_W-1:0] w_arm_in;

        if (s == 0) begin : g_first
            assign w_in     = r1_cor;
            assign w_ctl_in = w_ctl_s2;
            assign w_arm_in = r1_arm;
        end else begin : g_next
            assign w_in     = r_c_cor[s-1];
            assign w_ctl_in = r_c_ctl[s-1];
            assign w_arm_in = r_c_arm[s-1];
        end

        tfpg_cordic_stage #(
            .FIRST (s * CORDIC_PER_STAGE)
        ) u_stage (
            .i_cor (w_in),
            .o_cor (w_out)
        );

        always_ff @(posedge i_clk) begin
            if (w_move[s+1]) begin
                r_c_cor[s] <= w_out;
                r_c_ctl[s] <= w_ctl_in;
                r_c_arm[s] <= w_arm_in;
            end
        end
    end

    // ---------------- stage 6: rounded center bearing ----------------
    logic signed [Z_W-1:0]            w_zf, w_zr;
    logic signed [BEAR_W-1:0]         r6_bear;
    t_ctl                             r6_ctl;
    logic [MAX_ARMORS-1:0][YAW_W-1:0] r6_arm;

    assign w_zf = $signed(r_c_cor[CORDIC_STAGES-1].z);
    assign w_zr = (w_zf + ROUND_ADD) >>> ROUND_SH;

    always_ff @(posedge i_clk) begin
        if (w_move[NST-2]) begin
            // origin target has bearing zero
            r6_bear <= r_c_ctl[CORDIC_STAGES-1].origin ? '0 : w_zr[BEAR_W-1:0];
            r6_ctl  <= r_c_ctl[CORDIC_STAGES-1];
            r6_arm  <= r_c_arm[CORDIC_STAGES-1];
        end
    end

    // ---------------- output: armor facing and fire ----------------
    logic [MAX_ARMORS-1:0] w_hit;

    // lane k is in use when count > k; counts above MAX_ARMORS saturate
    for (genvar k = 0; k < MAX_ARMORS; k++) begin : g_lane
        tfpg_facing u_facing (
            .i_yaw    ($signed(r6_arm[k])),
            .i_bear   (r6_bear),
            .i_limit  (w_cfg.spin_angle),
            .i_active (r6_ctl.count > CNT_W'(k)),
            .o_hit    (w_hit[k])
        );
    end

    assign n_o_fire = r6_ctl.gate && r6_ctl.pass && (!r6_ctl.center || (|w_hit));

    always_ff @(posedge i_clk) begin
        if (w_move[NST-1]) begin
            r_o_fire <= n_o_fire;
        end
    end

    assign o_valid = r_o_valid;
    assign o_fire  = r_o_fire;

    // ---------------- assertions ----------------
    a_prev_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_gate) |=> (r_prev == $past(i_command_yaw)))
        else $error("stored yaw not taken from engaged tick");

    a_prev_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_acc && w_gate) |=> $stable(r_prev))
        else $error("stored yaw changed without engaged tick");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && r_o_valid && i_stall))
        else $error("input stalled with room in the pipe");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && !w_move[NST-1]) |=> r_vld[NST-1])
        else $error("tick lost in last stage");

endmodule

[hw/rtl/tfpg_cfg_regs.sv]
// ---------------------------------------------------------------------------
// tfpg_cfg_regs - configuration register file
// Write-only registers for tolerances, judge distance, auto fire and
// spin fire angle. Unknown indexes are dropped.
// ---------------------------------------------------------------------------
module tfpg_cfg_regs
    import tfpg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_tol   <= NEAR_TOL_RST;
            r_cfg.far_tol    <= FAR_TOL_RST;
            r_cfg.judge_dist <= JUDGE_DIST_RST;
            r_cfg.auto_fire  <= AUTO_FIRE_RST;
            r_cfg.spin_angle <= SPIN_ANGLE_RST;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_idx))
                CFG_NEAR_TOL:   r_cfg.near_tol   <= i_data[TOL_W-1:0];
                CFG_FAR_TOL:    r_cfg.far_tol    <= i_data[TOL_W-1:0];
                CFG_JUDGE_DIST: r_cfg.judge_dist <= i_data[DIST_W-1:0];
                CFG_AUTO_FIRE:  r_cfg.auto_fire  <= i_data[0];
                CFG_SPIN_ANGLE: r_cfg.spin_angle <= i_data[SPIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/tfpg_cordic_stage.sv]
// ---------------------------------------------------------------------------
// tfpg_cordic_stage - group of CORDIC vectoring iterations
// Drives y toward zero, accumulating the rotation in z. FIRST is the
// iteration number of the first step in this group.
// ---------------------------------------------------------------------------
module tfpg_cordic_stage
    import tfpg_pkg::*;
#(
    parameter int FIRST = 0
)
(
    input  t_cordic i_cor,
    output t_cordic o_cor
);

    logic signed [CORDIC_W-1:0] x, y, dx, dy;
    logic signed [Z_W-1:0]      z, da;

    always_comb begin
        x = $signed(i_cor.x);
        y = $signed(i_cor.y);
        z = $signed(i_cor.z);
        for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
            dx = y >>> (FIRST + j);
            dy = x >>> (FIRST + j);
            da = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_Q16[ATAN_IDX_W'(FIRST + j)]});
            // y >= 0: rotate clockwise
            if (!y[CORDIC_W-1]) begin
                x = x + dx;
                y = y - dy;
                z = z + da;
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - da;
            end
        end
        o_cor.x = x;
        o_cor.y = y;
        o_cor.z = z;
    end

endmodule

[hw/rtl/tfpg_facing.sv]
// ---------------------------------------------------------------------------
// tfpg_facing - armor facing check for one lane
// Wraps armor yaw minus center bearing into (-pi, pi] and compares its
// magnitude with the spin fire angle.
// ---------------------------------------------------------------------------
module tfpg_facing
    import tfpg_pkg::*;
(
    input  logic signed [YAW_W-1:0]  i_yaw,
    input  logic signed [BEAR_W-1:0] i_bear,
    input  logic        [SPIN_W-1:0] i_limit,
    input  logic                     i_active,
    output logic                     o_hit
);

    logic signed [WRAP_W-1:0] d0, d1, d2, d3, d4, mag;

    // offset stays within +-5*pi, so two corrections each way are enough
    always_comb begin
        d0    = WRAP_W'(i_yaw) - WRAP_W'(i_bear);
        d1    = (d0 > PI_Q12) ? d0 - TWO_PI_Q12 : d0;
        d2    = (d1 > PI_Q12) ? d1 - TWO_PI_Q12 : d1;
        d3    = (d2 <= -PI_Q12) ? d2 + TWO_PI_Q12 : d2;
        d4    = (d3 <= -PI_Q12) ? d3 + TWO_PI_Q12 : d3;
        mag   = d4[WRAP_W-1] ? -d4 : d4;
        o_hit = i_active && (mag < $signed({{(WRAP_W-SPIN_W){1'b0}}, i_limit}));
    end

endmodule
